[sv/avir_pkg.sv]
package avir_pkg;

    localparam int AVG_DEPTH_DEF = 8;
    localparam int SAMPLE_W      = 12;
    localparam int SAMPLE_MAX    = 4095;
    localparam int VREF_MV       = 2500;
    localparam int DIVIDER_RATIO = 20;
    localparam int MV_FULL       = VREF_MV * DIVIDER_RATIO;
    localparam int MV_MAX        = 50000;
    localparam int MV_W          = 16;
    localparam int ADC_SHIFT     = 12;
    localparam int TCODE_W       = 12;
    localparam int ERR_W         = MV_W + 1;
    localparam int ERR_DIV       = 30;
    localparam int ERR_SHIFT     = 20;
    localparam int ERR_RECIP     = ((1 << ERR_SHIFT) + ERR_DIV - 1) / ERR_DIV;
    localparam int DUTY_W        = 24;
    localparam int DUTY_MAX      = 8388607;
    localparam int DUTY_MIN      = -8388608;

    typedef enum logic
    {
        CMD_VOUT     = 1'b0,
        CMD_SETPOINT = 1'b1
    } command_t;

    typedef struct packed
    {
        logic               done;
        logic               enable;
        logic [TCODE_W-1:0] target_code;
    } s0_side_t;

    typedef struct packed
    {
        logic                    done;
        logic                    enable;
        logic [MV_W-1:0]         target_mv;
        logic [MV_W-1:0]         measured_mv;
        logic signed [ERR_W-1:0] err;
    } scale_out_t;

endpackage

[sv/avir_scale_pipe.sv]
module avir_scale_pipe
#(
    parameter int AVG_DEPTH = avir_pkg::AVG_DEPTH_DEF,
    localparam int SUM_W = $clog2(AVG_DEPTH * avir_pkg::SAMPLE_MAX + 1)
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [SUM_W-1:0]     in_sum,
    input  avir_pkg::s0_side_t   in_side,
    output logic                 out_valid,
    input  logic                 out_ready,
    output avir_pkg::scale_out_t out_data
);
    import avir_pkg::*;

    localparam int PROD_W = SUM_W + MV_W;
    localparam int Q_W    = PROD_W - ADC_SHIFT;
    localparam longint RECIP = (64'd1 << Q_W) / AVG_DEPTH;

    logic                v1_reg, v2_reg, v3_reg;
    logic                r1, r2, r3;
    s0_side_t            side1_reg, side2_reg;
    logic [MV_W-1:0]     tmv1_reg, tmv2_reg;
    logic [PROD_W-1:0]   prod1_reg;
    logic [Q_W-1:0]      q2_reg, est2_reg;
    scale_out_t          res3_reg;

    logic [PROD_W-1:0]   prod1_next;
    logic [MV_W-1:0]     tmv1_next;
    logic [Q_W-1:0]      q2_next;
    logic [2*Q_W-1:0]    est_prod;
    logic [Q_W-1:0]      est2_next;
    logic [Q_W-1:0]      rem;
    logic [Q_W-1:0]      meas_full;
    logic [MV_W-1:0]     meas;
    scale_out_t          res3_next;

    assign r3       = !v3_reg || out_ready;
    assign r2       = !v2_reg || r3;
    assign r1       = !v1_reg || r2;
    assign in_ready = r1;

    assign prod1_next = PROD_W'(in_sum) * PROD_W'(MV_FULL);
    assign tmv1_next  = MV_W'(MV_W'(in_side.target_code) * MV_W'(DIVIDER_RATIO));

    assign q2_next   = prod1_reg[PROD_W-1:ADC_SHIFT];
    assign est_prod  = (2*Q_W)'(q2_next) * (2*Q_W)'(RECIP);
    assign est2_next = est_prod[2*Q_W-1:Q_W];

    // The reciprocal estimate is at most one below the true quotient.
    assign rem       = q2_reg - Q_W'(est2_reg * Q_W'(AVG_DEPTH));
    assign meas_full = (rem >= Q_W'(AVG_DEPTH)) ? est2_reg + Q_W'(1) : est2_reg;
    assign meas      = meas_full[MV_W-1:0];

    always_comb
    begin
        res3_next.done        = side2_reg.done;
        res3_next.enable      = side2_reg.enable;
        res3_next.target_mv   = tmv2_reg;
        res3_next.measured_mv = meas;
        res3_next.err         = $signed({1'b0, tmv2_reg}) - $signed({1'b0, meas});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (r1)
            begin
                v1_reg <= in_valid;
            end
            if (r2)
            begin
                v2_reg <= v1_reg;
            end
            if (r3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (r1 && in_valid)
        begin
            prod1_reg <= prod1_next;
            tmv1_reg  <= tmv1_next;
            side1_reg <= in_side;
        end
        if (r2 && v1_reg)
        begin
            q2_reg    <= q2_next;
            est2_reg  <= est2_next;
            tmv2_reg  <= tmv1_reg;
            side2_reg <= side1_reg;
        end
        if (r3 && v2_reg)
        begin
            res3_reg <= res3_next;
        end
    end

    assign out_valid = v3_reg;
    assign out_data  = res3_reg;

endmodule

[sv/averaged_voltage_integral_regulator_top.sv]
// Averaged voltage integral regulator.
// The slave channel carries one ADC conversion per transfer. s_tuser selects
// the kind of sample: an output-voltage reading or a setpoint reading.
// Setpoint readings update the target in millivolts; output-voltage readings
// are summed in blocks of AVG_DEPTH, and the block average becomes the
// measured value in millivolts. When output is enabled at the end of a block,
// the duty accumulator integrates a thirtieth of the error and saturates at
// the signed 24-bit limits.
// Every accepted transfer produces exactly one result transfer on the master
// channel, in order; m_tlast marks the result of the sample that ended a block.
// A result passes through the input register and then one register each for
// the scaling product, the reciprocal estimate, the quotient correction and
// the duty update.
// One transfer per cycle is sustained while m_tready stays high; the stages are
// valid-gated, so bubbles close up and a held result does not stop earlier
// stages from filling. When the receiver stalls, the result register holds
// and s_tready drops once every stage is full.
// Reset clears the sum, the sample count, the target, the measured value, the
// duty accumulator and all valid flags.
module averaged_voltage_integral_regulator_top
#(
    parameter int AVG_DEPTH = avir_pkg::AVG_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,  // sample[11:0], output_enable[12], zero[15:13]
    input  logic [0:0]  s_tuser,  // command[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,  // measured_mv[15:0], target_mv[31:16],
                                  // duty_value[55:32]
    output logic        m_tlast
);
    import avir_pkg::*;

    localparam int SUM_W = $clog2(AVG_DEPTH * SAMPLE_MAX + 1);
    localparam int CNT_W = $clog2(AVG_DEPTH);
    localparam int TPROD_W = SAMPLE_W + 12;

    logic [SAMPLE_W-1:0]   sample;
    logic                  output_enable;
    command_t              command;
    logic                  in_xfer;

    logic [SUM_W-1:0]      sum_reg, sum_next;
    logic [CNT_W-1:0]      count_reg;
    logic [TCODE_W-1:0]    tcode_reg, tcode_next;
    logic [TPROD_W-1:0]    tprod;
    logic                  block_end;

    logic                  st0_valid_reg;
    logic [SUM_W-1:0]      st0_sum_reg;
    s0_side_t              st0_side_reg, st0_side_next;
    logic                  pipe_in_ready;

    logic                  pipe_valid;
    logic                  pipe_ready;
    scale_out_t            pipe_data;
    logic                  pipe_xfer;

    logic [MV_W-1:0]       measured_reg;
    logic [MV_W-1:0]       target_out_reg;
    logic                  done_out_reg;
    logic                  out_valid_reg;
    logic signed [DUTY_W-1:0] duty_reg, duty_next;

    logic [ERR_W-1:0]      abs_err;
    logic [31:0]           quot_prod;
    logic [ERR_W-1:0]      quot_mag;
    logic signed [ERR_W-1:0] step;
    logic signed [DUTY_W:0]  duty_sum;

    assign sample        = s_tdata[SAMPLE_W-1:0];
    assign output_enable = s_tdata[SAMPLE_W];
    assign command       = command_t'(s_tuser[0]);

    assign s_tready = !st0_valid_reg || pipe_in_ready;
    assign in_xfer  = s_tvalid && s_tready;

    assign tprod     = TPROD_W'(sample) * TPROD_W'(VREF_MV);
    assign sum_next  = sum_reg + SUM_W'(sample);
    assign block_end = (command == CMD_VOUT) && (count_reg == CNT_W'(AVG_DEPTH - 1));

    always_comb
    begin
        tcode_next = tcode_reg;
        case (command)
            CMD_SETPOINT: tcode_next = tprod[TPROD_W-1:ADC_SHIFT];
            default:      tcode_next = tcode_reg;
        endcase
        st0_side_next.done        = block_end;
        st0_side_next.enable      = output_enable;
        st0_side_next.target_code = tcode_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg       <= '0;
            count_reg     <= '0;
            tcode_reg     <= '0;
            st0_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                st0_valid_reg <= s_tvalid;
            end
            if (in_xfer)
            begin
                tcode_reg <= tcode_next;
                if (command == CMD_VOUT)
                begin
                    if (block_end)
                    begin
                        sum_reg   <= '0;
                        count_reg <= '0;
                    end
                    else
                    begin
                        sum_reg   <= sum_next;
                        count_reg <= count_reg + CNT_W'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            st0_sum_reg  <= sum_next;
            st0_side_reg <= st0_side_next;
        end
    end

    avir_scale_pipe #(
        .AVG_DEPTH (AVG_DEPTH)
    ) u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (st0_valid_reg),
        .in_ready  (pipe_in_ready),
        .in_sum    (st0_sum_reg),
        .in_side   (st0_side_reg),
        .out_valid (pipe_valid),
        .out_ready (pipe_ready),
        .out_data  (pipe_data)
    );

    assign pipe_ready = !out_valid_reg || m_tready;
    assign pipe_xfer  = pipe_valid && pipe_ready;

    // Quotient by thirty through a rounded-up reciprocal, exact for this range.
    assign abs_err   = pipe_data.err[ERR_W-1] ? ERR_W'(-pipe_data.err) : ERR_W'(pipe_data.err);
    assign quot_prod = 32'(abs_err[MV_W-1:0]) * 32'(ERR_RECIP);
    assign quot_mag  = ERR_W'(quot_prod >> ERR_SHIFT);
    assign step      = pipe_data.err[ERR_W-1] ? -$signed(quot_mag) : $signed(quot_mag);
    assign duty_sum  = $signed({duty_reg[DUTY_W-1], duty_reg})
                     + $signed({{(DUTY_W + 1 - ERR_W){step[ERR_W-1]}}, step});

    always_comb
    begin
        if (duty_sum > (DUTY_W + 1)'(DUTY_MAX))
        begin
            duty_next = DUTY_W'(DUTY_MAX);
        end
        else if (duty_sum < $signed((DUTY_W + 1)'(DUTY_MIN)))
        begin
            duty_next = DUTY_W'(DUTY_MIN);
        end
        else
        begin
            duty_next = duty_sum[DUTY_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            measured_reg  <= '0;
            duty_reg      <= '0;
        end
        else
        begin
            if (pipe_ready)
            begin
                out_valid_reg <= pipe_valid;
            end
            if (pipe_xfer && pipe_data.done)
            begin
                measured_reg <= pipe_data.measured_mv;
                if (pipe_data.enable)
                begin
                    duty_reg <= duty_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_xfer)
        begin
            target_out_reg <= pipe_data.target_mv;
            done_out_reg   <= pipe_data.done;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {duty_reg, target_out_reg, measured_reg};
    assign m_tlast  = done_out_reg;

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(AVG_DEPTH - 1))
        else $error("sample count left its range");

    a_duty_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !(pipe_xfer && pipe_data.done && pipe_data.enable) |=> $stable(duty_reg))
        else $error("duty changed without an enabled block end");

    a_measured_range: assert property (@(posedge clk) disable iff (!rst_n)
        measured_reg <= MV_W'(MV_MAX))
        else $error("measured value above full scale");

    a_measured_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !(pipe_xfer && pipe_data.done) |=> $stable(measured_reg))
        else $error("measured value changed outside a block end");

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (st0_valid_reg && out_valid_reg && !m_tready))
        else $error("input stalled while the pipeline had room");

endmodule

[bench/avir_regulator_checker.sv]
module avir_regulator_checker
#(
    parameter int AVG_DEPTH = avir_pkg::AVG_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,  // sample[11:0], output_enable[12], zero[15:13]
    input  logic [0:0]  s_tuser,  // command[0]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [55:0] m_tdata,  // measured_mv[15:0], target_mv[31:16],
                                  // duty_value[55:32]
    input  logic        m_tlast,
    output int          mismatch_count,
    output int          outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import avir_pkg::*;

    typedef struct packed
    {
        logic [MV_W-1:0]          measured_mv;
        logic [MV_W-1:0]          target_mv;
        logic signed [DUTY_W-1:0] duty_value;
        logic                     block_done;
    } regulator_out_t;

    regulator_out_t  predicted_outputs[$];
    int unsigned     block_sum;
    int unsigned     block_fill;
    logic [MV_W-1:0] avg_mv;
    logic [MV_W-1:0] setpoint_mv;
    int              duty_int;

    function automatic regulator_out_t regulate(input command_t cmd, input logic [11:0] smp,
                                                input logic en);
        regulator_out_t r;
        longint         scaled;
        int             next_duty;
        r.block_done = 1'b0;
        if (cmd == CMD_SETPOINT)
        begin
            setpoint_mv = MV_W'(((int'(smp) * VREF_MV) >> ADC_SHIFT) * DIVIDER_RATIO);
        end
        else
        begin
            block_sum += smp;
            block_fill++;
            if (block_fill >= AVG_DEPTH)
            begin
                scaled = longint'(block_sum) * MV_FULL;
                avg_mv = MV_W'((scaled / AVG_DEPTH) >> ADC_SHIFT);
                block_sum = 0;
                block_fill = 0;
                r.block_done = 1'b1;
                if (en)
                begin
                    next_duty = duty_int + (int'(setpoint_mv) - int'(avg_mv)) / ERR_DIV;
                    if (next_duty > DUTY_MAX)
                    begin
                        next_duty = DUTY_MAX;
                    end
                    if (next_duty < DUTY_MIN)
                    begin
                        next_duty = DUTY_MIN;
                    end
                    duty_int = next_duty;
                end
            end
        end
        r.measured_mv = avg_mv;
        r.target_mv = setpoint_mv;
        r.duty_value = DUTY_W'(duty_int);
        return r;
    endfunction

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        regulator_out_t want;
        if (!rst_n)
        begin
            block_sum = 0;
            block_fill = 0;
            avg_mv = '0;
            setpoint_mv = '0;
            duty_int = 0;
            predicted_outputs.delete();
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (predicted_outputs.size() == 0)
                begin
                    $error("result transfer with no prediction outstanding");
                    mismatch_count++;
                end
                else
                begin
                    want = predicted_outputs.pop_front();
                    check_field("measured_mv", want.measured_mv, m_tdata[15:0]);
                    check_field("target_mv", want.target_mv, m_tdata[31:16]);
                    check_field("duty_value", want.duty_value, $signed(m_tdata[55:32]));
                    check_field("block_done", want.block_done, m_tlast);
                end
            end
            if (s_tvalid && s_tready)
            begin
                predicted_outputs.push_back(regulate(command_t'(s_tuser[0]), s_tdata[11:0],
                                                     s_tdata[12]));
            end
        end
        outstanding = predicted_outputs.size();
    end

endmodule

[bench/averaged_voltage_integral_regulator_top_test.sv]
module averaged_voltage_integral_regulator_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import avir_pkg::*;

    localparam int DEPTH        = AVG_DEPTH_DEF;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int RANDOM_ITEMS = 1450;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic [0:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;
    logic        m_tlast;
    int          send_gap = 19;
    int          stall_rate = 68;
    int          cycle_count = 0;
    int          mismatches;
    int          outstanding;

    averaged_voltage_integral_regulator_top #(.AVG_DEPTH(DEPTH)) i_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    avir_regulator_checker #(.AVG_DEPTH(DEPTH)) i_checker
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tlast        (m_tlast),
        .mismatch_count (mismatches),
        .outstanding    (outstanding)
    );

    always #4 clk = ~clk;

    always @(negedge clk)
    begin
        m_tready <= ($urandom_range(99) >= stall_rate);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic send_sample(input command_t cmd, input logic [11:0] smp, input logic en);
        while ($urandom_range(99) < send_gap)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= {3'b000, en, smp};
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
    endtask

    task automatic send_random_item();
        command_t    cmd;
        logic [11:0] smp;
        int          pick;
        cmd = ($urandom_range(5) == 0) ? CMD_SETPOINT : CMD_VOUT;
        pick = $urandom_range(7);
        smp = (pick == 0) ? 12'h000 : (pick == 1) ? 12'hFFF : 12'($urandom);
        send_sample(cmd, smp, $urandom_range(4) != 0);
    endtask

    initial
    begin
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        send_sample(CMD_SETPOINT, 12'hFFF, 1'b0);
        repeat (DEPTH) send_sample(CMD_VOUT, 12'h000, 1'b1);
        send_sample(CMD_SETPOINT, 12'h000, 1'b1);
        repeat (DEPTH - 1) send_sample(CMD_VOUT, 12'hFFF, 1'b1);
        send_sample(CMD_VOUT, 12'hFFF, 1'b0);
        send_sample(CMD_SETPOINT, 12'h800, 1'b0);
        send_sample(CMD_VOUT, 12'h800, 1'b1);
        send_sample(CMD_VOUT, 12'h7FF, 1'b0);
        send_sample(CMD_VOUT, 12'h555, 1'b1);
        send_sample(CMD_VOUT, 12'hAAA, 1'b1);

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == RANDOM_ITEMS / 3)
            begin
                send_gap = 68;
                stall_rate = 19;
            end
            if (i == 2 * RANDOM_ITEMS / 3)
            begin
                send_gap = 0;
                stall_rate = 0;
            end
            send_random_item();
        end
        s_tvalid <= 1'b0;

        while (outstanding != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
